FILE: src/sbad_pkg.sv
// Package for the sound bus address decoder: beat structs, route and command
// codes, sizes of the sound RAM and of the front-to-back queue.
// No dependencies.
package sbad_pkg;

    localparam int SOUND_RAM_DEPTH = 8192;
    localparam int RAM_AW          = $clog2(SOUND_RAM_DEPTH);
    localparam int ROM_AW          = 22;
    localparam int Q_DEPTH         = 4;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int Q_CW            = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_BOARD_MODE = 1'b0;
    localparam logic CFG_ROM_HALF   = 1'b1;

    // Board modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_AUDIO = 2'd1;

    // Bus commands
    localparam logic [2:0] CMD_DATA_RD  = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_OPCODE   = 3'd2;
    localparam logic [2:0] CMD_OPERAND  = 3'd3;
    localparam logic [2:0] CMD_HOST_CMD = 3'd4;
    localparam logic [2:0] CMD_HOST_FADE = 3'd5;

    // Result routes
    localparam logic [2:0] ROUTE_OPEN    = 3'd0;
    localparam logic [2:0] ROUTE_ROM     = 3'd1;
    localparam logic [2:0] ROUTE_INT     = 3'd2;
    localparam logic [2:0] ROUTE_PORT_RD = 3'd3;
    localparam logic [2:0] ROUTE_PORT_WR = 3'd4;
    localparam logic [2:0] ROUTE_STATUS  = 3'd5;
    localparam logic [2:0] ROUTE_CMD_WR  = 3'd6;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in;

    typedef struct packed {
        logic [2:0]  route;
        logic [21:0] external_address;
        logic [7:0]  read_data;
        logic [7:0]  external_data;
        logic [15:0] audio_register;
    } t_res;

    // Operation classes handed from the front to the back
    typedef enum logic [3:0] {
        K_OPEN,
        K_ROM,
        K_PORT_RD,
        K_PORT_WR,
        K_STATUS,
        K_CMD_WR,
        K_RAM_RD,
        K_RAM_WR,
        K_CMD_RD,
        K_FADE_RD,
        K_CMD_LD,
        K_FADE_LD,
        K_BANK_WR,
        K_ACH_WR,
        K_ACL_WR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        use_bank;
        logic [21:0] addr;
        logic [7:0]  data;
    } t_op;

endpackage

FILE: src/sound_bus_address_decoder_core.sv
// Sound bus address decoder: one result beat per accepted bus beat, in order.
// A beat accepted is written into the queue, then registered into the result register when the back takes it.
// Throughput: one beat per cycle while results are popped; an untaken result stalls the back.
// Reset (synchronous, active low) clears the queue, the latches and the bank,
// then all 8192 entries of the sound RAM are swept to zero with full held high.
// Depends on sbad_pkg, sbad_front, sbad_queue, sbad_back.
module sound_bus_address_decoder_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [21:0]    i_cfg_data,
    input  logic           push,
    input  sbad_pkg::t_in  i_item,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output sbad_pkg::t_res o_result
);
    import sbad_pkg::*;

    t_op  w_push_op;
    t_op  w_head_op;
    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_empty;
    logic w_init_done;

    sbad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_q_full    (w_q_full),
        .i_init_done (w_init_done),
        .o_q_push    (w_q_push),
        .o_q_op      (w_push_op)
    );

    sbad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_push_op),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_op    (w_head_op),
        .o_empty (w_q_empty)
    );

    sbad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_op      (w_head_op),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .o_init_done (w_init_done),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

FILE: src/sbad_front.sv
// Front of the sound bus address decoder: accepts bus beats, holds the
// configuration registers and classifies each access into a t_op.
// Depends on sbad_pkg.
module sbad_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [21:0]   i_cfg_data,
    input  logic          i_push,
    input  sbad_pkg::t_in i_item,
    output logic          o_full,
    input  logic          i_q_full,
    input  logic          i_init_done,
    output logic          o_q_push,
    output sbad_pkg::t_op o_q_op
);
    import sbad_pkg::*;

    localparam logic [15:0] A_ROM_TOP  = 16'h8000;
    localparam logic [15:0] A_BANK_TOP = 16'hC000;
    localparam logic [15:0] A_D000     = 16'hD000;
    localparam logic [15:0] A_D800     = 16'hD800;
    localparam logic [15:0] A_F000     = 16'hF000;
    localparam logic [15:0] A_PORT1    = 16'hF001;
    localparam logic [15:0] A_PORT2    = 16'hF002;
    localparam logic [15:0] A_BANK_REG = 16'hF004;
    localparam logic [15:0] A_CMD_LAT  = 16'hF008;
    localparam logic [15:0] A_FADE_LAT = 16'hF00A;
    localparam logic [15:0] A_STATUS   = 16'hD007;
    localparam logic [15:0] A_ACH      = 16'hD000;
    localparam logic [15:0] A_ACL      = 16'hD001;
    localparam logic [15:0] A_ACMD     = 16'hD002;
    localparam logic [15:0] A_ABANK    = 16'hD003;

    logic [1:0]  r_board_mode;
    logic [21:0] r_rom_half;
    t_op         w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_mode <= MODE_PLAIN;
            r_rom_half   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BOARD_MODE: r_board_mode <= i_cfg_data[1:0];
                CFG_ROM_HALF:   r_rom_half   <= i_cfg_data;
                default:        r_board_mode <= r_board_mode;
            endcase
        end
    end

    function automatic t_op f_mk(input t_kind kind, input logic use_bank,
                                 input logic [21:0] addr);
        t_op op;
        op          = '0;
        op.kind     = kind;
        op.use_bank = use_bank;
        op.addr     = addr;
        return op;
    endfunction

    function automatic t_op f_data_rd(input logic [15:0] a, input logic [1:0] mode);
        t_op op;
        if (a < A_ROM_TOP) begin
            op = f_mk(K_ROM, 1'b0, 22'(a));
        end else if (a < A_BANK_TOP) begin
            op = f_mk(K_ROM, 1'b1, 22'(a));
        end else if (mode == MODE_PLAIN) begin
            if (a < A_D000) begin
                op = f_mk(K_ROM, 1'b0, 22'(a[11:0]));
            end else if (a < A_D800) begin
                op = f_mk(K_RAM_RD, 1'b0, 22'(a[10:0]));
            end else if (a < A_F000) begin
                op = f_mk(K_ROM, 1'b0, 22'(a - A_D800));
            end else if (a == A_PORT1 || a == A_PORT2) begin
                op = f_mk(K_PORT_RD, 1'b0, 22'(a[3:0]));
            end else if (a == A_CMD_LAT) begin
                op = f_mk(K_CMD_RD, 1'b0, '0);
            end else if (a == A_FADE_LAT) begin
                op = f_mk(K_FADE_RD, 1'b0, '0);
            end else begin
                op = f_mk(K_OPEN, 1'b0, '0);
            end
        end else if (a < A_D000) begin
            op = f_mk(K_RAM_RD, 1'b0, 22'(a[11:0]));
        end else if (a < A_F000) begin
            op = f_mk((a == A_STATUS) ? K_STATUS : K_OPEN, 1'b0, '0);
        end else if (mode == MODE_AUDIO && a == A_CMD_LAT) begin
            op = f_mk(K_CMD_RD, 1'b0, '0);
        end else if (mode == MODE_AUDIO && a == A_FADE_LAT) begin
            op = f_mk(K_FADE_RD, 1'b0, '0);
        end else begin
            op = f_mk(K_RAM_RD, 1'b0, 22'({1'b1, a[11:0]}));
        end
        return op;
    endfunction

    function automatic t_op f_opcode(input logic [15:0] a, input logic [1:0] mode,
                                     input logic [21:0] half);
        t_op         op;
        logic        mid;
        logic [21:0] sum;
        mid = (a >= A_D000) && (a < A_F000);
        sum = half + 22'(a);
        if (mode > MODE_AUDIO && mid) begin
            op = f_mk(K_ROM, 1'b0, 22'(a));
        end else if (mode == MODE_AUDIO && (a < A_ROM_TOP || mid)) begin
            op = f_mk(K_ROM, 1'b0, sum);
        end else if (mode == MODE_AUDIO && a < A_BANK_TOP) begin
            op = f_mk(K_ROM, 1'b1, sum);
        end else begin
            op = f_data_rd(a, mode);
        end
        return op;
    endfunction

    function automatic t_op f_write(input logic [15:0] a, input logic [1:0] mode);
        t_op op;
        if (a < A_BANK_TOP) begin
            op = f_mk(K_OPEN, 1'b0, '0);
        end else if (mode == MODE_PLAIN) begin
            if (a < A_D000) begin
                op = f_mk(K_OPEN, 1'b0, '0);
            end else if (a < A_D800) begin
                op = f_mk(K_RAM_WR, 1'b0, 22'(a[10:0]));
            end else if (a < A_F000) begin
                op = f_mk(K_OPEN, 1'b0, '0);
            end else if (a == A_F000 || a == A_PORT1 || a == A_PORT2) begin
                op = f_mk(K_PORT_WR, 1'b0, 22'(a[3:0]));
            end else if (a == A_BANK_REG) begin
                op = f_mk(K_BANK_WR, 1'b0, '0);
            end else if (a == A_CMD_LAT) begin
                op = f_mk(K_CMD_LD, 1'b0, '0);
            end else if (a == A_FADE_LAT) begin
                op = f_mk(K_FADE_LD, 1'b0, '0);
            end else begin
                op = f_mk(K_OPEN, 1'b0, '0);
            end
        end else if (a < A_D000) begin
            op = f_mk(K_RAM_WR, 1'b0, 22'(a[11:0]));
        end else if (a < A_F000) begin
            if (a == A_ACH) begin
                op = f_mk(K_ACH_WR, 1'b0, '0);
            end else if (a == A_ACL) begin
                op = f_mk(K_ACL_WR, 1'b0, '0);
            end else if (a == A_ACMD) begin
                op = f_mk(K_CMD_WR, 1'b0, '0);
            end else if (a == A_ABANK) begin
                op = f_mk(K_BANK_WR, 1'b0, '0);
            end else begin
                op = f_mk(K_OPEN, 1'b0, '0);
            end
        end else if (mode == MODE_AUDIO && a == A_CMD_LAT) begin
            op = f_mk(K_CMD_LD, 1'b0, '0);
        end else if (mode == MODE_AUDIO && a == A_FADE_LAT) begin
            op = f_mk(K_FADE_LD, 1'b0, '0);
        end else begin
            op = f_mk(K_RAM_WR, 1'b0, 22'({1'b1, a[11:0]}));
        end
        return op;
    endfunction

    always_comb begin
        case (i_item.command)
            CMD_DATA_RD: w_op = f_data_rd(i_item.address, r_board_mode);
            CMD_WRITE:   w_op = f_write(i_item.address, r_board_mode);
            CMD_OPCODE:  w_op = f_opcode(i_item.address, r_board_mode, r_rom_half);
            CMD_OPERAND: begin
                // operand fetches on the audio board skip the decrypted half
                if (r_board_mode == MODE_AUDIO) begin
                    w_op = f_opcode(i_item.address, r_board_mode, '0);
                end else begin
                    w_op = f_opcode(i_item.address, r_board_mode, r_rom_half);
                end
            end
            CMD_HOST_CMD:  w_op = f_mk(K_CMD_LD, 1'b0, '0);
            CMD_HOST_FADE: w_op = f_mk(K_FADE_LD, 1'b0, '0);
            default:       w_op = f_mk(K_OPEN, 1'b0, '0);
        endcase
        w_op.data = i_item.write_data;
    end

    assign o_full   = i_q_full || !i_init_done;
    assign o_q_push = i_push && !o_full;
    assign o_q_op   = w_op;

endmodule

FILE: src/sbad_queue.sv
// Short queue of classified operations between front and back.
// Depends on sbad_pkg.
module sbad_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbad_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output sbad_pkg::t_op o_op,
    output logic          o_empty
);
    import sbad_pkg::*;

    t_op             r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");
    a_count_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");
`endif

endmodule

FILE: src/sbad_back.sv
// Back of the sound bus address decoder: sound RAM with its clearing sweep,
// bank/latch/command registers, execution of queued operations, result beat.
// Depends on sbad_pkg.
module sbad_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sbad_pkg::t_op  i_q_op,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output logic           o_init_done,
    input  logic           i_pop,
    output logic           o_empty,
    output sbad_pkg::t_res o_result
);
    import sbad_pkg::*;

    logic [7:0]        r_mem [SOUND_RAM_DEPTH];
    logic [RAM_AW-1:0] r_clr_addr;
    logic              r_init_done;
    logic [3:0]        r_bank;
    logic [7:0]        r_cmd_latch;
    logic [7:0]        r_fade_latch;
    logic [7:0]        r_ach;
    logic [7:0]        r_acl;
    logic              r_valid;
    logic              r_ram_rd;
    t_res              r_res;
    logic [7:0]        r_q;

    t_res              n_res;
    logic              w_adv;
    logic              w_we;
    logic [RAM_AW-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic [RAM_AW-1:0] w_idx;

    assign w_adv   = r_init_done && !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = w_adv;
    assign w_idx   = i_q_op.addr[RAM_AW-1:0];

    // Sweep the RAM to zero after reset, then take writes from the queue
    assign w_we    = !r_init_done || (w_adv && i_q_op.kind == K_RAM_WR);
    assign w_waddr = r_init_done ? w_idx : r_clr_addr;
    assign w_wdata = r_init_done ? i_q_op.data : 8'h00;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_q_op.kind == K_RAM_RD) begin
            r_q <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_init_done <= 1'b0;
        end else if (!r_init_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {RAM_AW{1'b1}}) begin
                r_init_done <= 1'b1;
            end
        end
    end

    always_comb begin
        n_res                  = '0;
        n_res.route            = ROUTE_INT;
        case (i_q_op.kind)
            K_OPEN: begin
                n_res.route     = ROUTE_OPEN;
                n_res.read_data = 8'hFF;
            end
            K_ROM: begin
                n_res.route = ROUTE_ROM;
                n_res.external_address = i_q_op.use_bank
                    ? i_q_op.addr + (ROM_AW'(r_bank) << 14) : i_q_op.addr;
            end
            K_PORT_RD: begin
                n_res.route            = ROUTE_PORT_RD;
                n_res.external_address = i_q_op.addr;
            end
            K_PORT_WR: begin
                n_res.route            = ROUTE_PORT_WR;
                n_res.external_address = i_q_op.addr;
                n_res.external_data    = i_q_op.data;
            end
            K_STATUS: n_res.route = ROUTE_STATUS;
            K_CMD_WR: begin
                n_res.route          = ROUTE_CMD_WR;
                n_res.external_data  = i_q_op.data;
                n_res.audio_register = {r_ach, r_acl};
            end
            K_CMD_RD:  n_res.read_data = r_cmd_latch;
            K_FADE_RD: n_res.read_data = r_fade_latch;
            default:   n_res.route = ROUTE_INT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= '0;
            r_cmd_latch  <= '0;
            r_fade_latch <= '0;
            r_ach        <= '0;
            r_acl        <= '0;
        end else if (w_adv) begin
            case (i_q_op.kind)
                K_CMD_LD:  r_cmd_latch  <= i_q_op.data;
                K_FADE_LD: r_fade_latch <= i_q_op.data;
                K_BANK_WR: r_bank       <= i_q_op.data[3:0];
                K_ACH_WR:  r_ach        <= i_q_op.data;
                K_ACL_WR:  r_acl        <= i_q_op.data;
                default:   r_bank       <= r_bank;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res    <= n_res;
            r_ram_rd <= (i_q_op.kind == K_RAM_RD);
        end
    end

    always_comb begin
        o_result = r_res;
        if (r_ram_rd) begin
            o_result.read_data = r_q;
        end
    end

    assign o_empty     = !r_valid;
    assign o_init_done = r_init_done;

`ifndef ASSERT_OFF
    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init_done |-> !r_valid)
        else $error("result present during RAM sweep");
    a_pop_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_init_done && !i_q_empty))
        else $error("queue popped while not ready");
    a_ram_rd_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ram_rd) |-> (r_res.route == ROUTE_INT))
        else $error("RAM read with non-internal route");
`endif

endmodule

FILE: sim/sound_bus_address_decoder_core_tb.sv
// Testbench for sound_bus_address_decoder_core: directed and random bus beats under
// every board mode, each result checked field by field against an in-bench decoder.
// Depends on sbad_pkg and the core with its front, queue and back.
module sound_bus_address_decoder_core_tb;
    import sbad_pkg::*;

    localparam logic [1:0] MODE_LATER    = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [21:0] HALF_MAX     = 22'h200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_BOARD_MODE;
    logic [21:0] i_cfg_data = '0;
    logic        push = 1'b0;
    t_in         i_item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_res        o_result;

    // Decoder state kept by the bench
    logic [7:0]  snd_ram [SOUND_RAM_DEPTH];
    logic [3:0]  bank_q;
    logic [7:0]  cmd_latch_q;
    logic [7:0]  fade_latch_q;
    logic [7:0]  acmd_hi_q;
    logic [7:0]  acmd_lo_q;
    logic [1:0]  mode_q;
    logic [21:0] half_q;

    t_res        decoded_q [$];
    int          err_cnt = 0;
    bit          bus_busy = 0;
    int          burst_left = 0;
    logic [15:0] recent_wr [8];
    int          wr_ptr = 0;
    int          stall_tick = 0;
    int          stall_style = 0;

    sound_bus_address_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(20 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- decoder

    function automatic t_res blank(input logic [2:0] route);
        t_res r;
        r = '0;
        r.route = route;
        if (route == ROUTE_OPEN) begin
            r.read_data = 8'hFF;
        end
        return r;
    endfunction

    function automatic t_res rom_at(input logic [31:0] a);
        t_res r;
        r = blank(ROUTE_ROM);
        r.external_address = a[ROM_AW-1:0];
        return r;
    endfunction

    function automatic t_res ram_rd(input logic [31:0] idx);
        t_res r;
        r = blank(ROUTE_INT);
        r.read_data = snd_ram[idx[RAM_AW-1:0]];
        return r;
    endfunction

    function automatic t_res ram_wr(input logic [31:0] idx, input logic [7:0] v);
        snd_ram[idx[RAM_AW-1:0]] = v;
        return blank(ROUTE_INT);
    endfunction

    function automatic t_res byte_rd(input logic [7:0] v);
        t_res r;
        r = blank(ROUTE_INT);
        r.read_data = v;
        return r;
    endfunction

    function automatic logic [31:0] banked(input logic [15:0] a);
        return (32'(bank_q) << 14) + 32'(a);
    endfunction

    function automatic t_res data_read(input logic [15:0] a);
        t_res r;
        if (a < 16'h8000) return rom_at(32'(a));
        if (a < 16'hC000) return rom_at(banked(a));
        if (mode_q == MODE_PLAIN) begin
            if (a < 16'hD000) return rom_at(32'(a) - 32'hC000);
            if (a < 16'hD800) return ram_rd(32'(a) - 32'hD000);
            if (a < 16'hF000) return rom_at((32'(a) - 32'hD800) & 32'h7FFF);
            if (a == 16'hF001 || a == 16'hF002) begin
                r = blank(ROUTE_PORT_RD);
                r.external_address = 22'(a[3:0]);
                return r;
            end
            if (a == 16'hF008) return byte_rd(cmd_latch_q);
            if (a == 16'hF00A) return byte_rd(fade_latch_q);
            return blank(ROUTE_OPEN);
        end
        if (a < 16'hD000) return ram_rd(32'(a) - 32'hC000);
        if (a < 16'hF000) return blank((a == 16'hD007) ? ROUTE_STATUS : ROUTE_OPEN);
        if (mode_q == MODE_AUDIO) begin
            if (a == 16'hF008) return byte_rd(cmd_latch_q);
            if (a == 16'hF00A) return byte_rd(fade_latch_q);
        end
        // later board: latch addresses fall through to RAM
        return ram_rd(32'h1000 + 32'(a) - 32'hF000);
    endfunction

    function automatic t_res opcode_read(input logic [15:0] a);
        if (mode_q >= MODE_LATER && a >= 16'hD000 && a < 16'hF000) return rom_at(32'(a));
        if (mode_q == MODE_AUDIO) begin
            if (a < 16'h8000) return rom_at(32'(half_q) + 32'(a));
            if (a < 16'hC000) return rom_at(32'(half_q) + banked(a));
            if (a >= 16'hD000 && a < 16'hF000) return rom_at(32'(half_q) + 32'(a));
        end
        return data_read(a);
    endfunction

    function automatic t_res operand_read(input logic [15:0] a);
        if (mode_q == MODE_AUDIO) begin
            if (a < 16'h8000) return rom_at(32'(a));
            if (a < 16'hC000) return rom_at(banked(a));
            if (a >= 16'hD000 && a < 16'hF000) return rom_at(32'(a));
        end
        return opcode_read(a);
    endfunction

    function automatic t_res bus_write(input logic [15:0] a, input logic [7:0] v);
        t_res r;
        if (a < 16'hC000) return blank(ROUTE_OPEN);
        if (mode_q == MODE_PLAIN) begin
            if (a < 16'hD000) return blank(ROUTE_OPEN);
            if (a < 16'hD800) return ram_wr(32'(a) - 32'hD000, v);
            if (a < 16'hF000) return blank(ROUTE_OPEN);
            case (a)
                16'hF000, 16'hF001, 16'hF002: begin
                    r = blank(ROUTE_PORT_WR);
                    r.external_address = 22'(a[3:0]);
                    r.external_data = v;
                    return r;
                end
                16'hF004: begin
                    bank_q = v[3:0];
                    return blank(ROUTE_INT);
                end
                16'hF008: begin
                    cmd_latch_q = v;
                    return blank(ROUTE_INT);
                end
                16'hF00A: begin
                    fade_latch_q = v;
                    return blank(ROUTE_INT);
                end
                default: return blank(ROUTE_OPEN);
            endcase
        end
        if (a < 16'hD000) return ram_wr(32'(a) - 32'hC000, v);
        if (a < 16'hF000) begin
            case (a)
                16'hD000: begin
                    acmd_hi_q = v;
                    return blank(ROUTE_INT);
                end
                16'hD001: begin
                    acmd_lo_q = v;
                    return blank(ROUTE_INT);
                end
                16'hD002: begin
                    r = blank(ROUTE_CMD_WR);
                    r.external_data = v;
                    r.audio_register = {acmd_hi_q, acmd_lo_q};
                    return r;
                end
                16'hD003: begin
                    bank_q = v[3:0];
                    return blank(ROUTE_INT);
                end
                default: return blank(ROUTE_OPEN);
            endcase
        end
        if (mode_q == MODE_AUDIO) begin
            if (a == 16'hF008) begin
                cmd_latch_q = v;
                return blank(ROUTE_INT);
            end
            if (a == 16'hF00A) begin
                fade_latch_q = v;
                return blank(ROUTE_INT);
            end
        end
        return ram_wr(32'h1000 + 32'(a) - 32'hF000, v);
    endfunction

    function automatic t_res decode_access(input t_in b);
        case (b.command)
            CMD_DATA_RD:   return data_read(b.address);
            CMD_WRITE:     return bus_write(b.address, b.write_data);
            CMD_OPCODE:    return opcode_read(b.address);
            CMD_OPERAND:   return operand_read(b.address);
            CMD_HOST_CMD: begin
                cmd_latch_q = b.write_data;
                return blank(ROUTE_INT);
            end
            CMD_HOST_FADE: begin
                fade_latch_q = b.write_data;
                return blank(ROUTE_INT);
            end
            default:       return blank(ROUTE_OPEN);
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_in access(input logic [2:0] c, input logic [15:0] a,
                                   input logic [7:0] d);
        t_in b;
        b.command = c;
        b.address = a;
        b.write_data = d;
        return b;
    endfunction

    function automatic logic [15:0] hot_address(input int k);
        case (k)
            0:  return 16'h0000;
            1:  return 16'h7FFF;
            2:  return 16'h8000;
            3:  return 16'hBFFF;
            4:  return 16'hC000;
            5:  return 16'hCFFF;
            6:  return 16'hD000;
            7:  return 16'hD001;
            8:  return 16'hD002;
            9:  return 16'hD003;
            10: return 16'hD007;
            11: return 16'hD7FF;
            12: return 16'hD800;
            13: return 16'hEFFF;
            14: return 16'hF000;
            15: return 16'hF001;
            16: return 16'hF002;
            17: return 16'hF004;
            18: return 16'hF008;
            19: return 16'hF00A;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic t_in random_access();
        t_in b;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      b.command = CMD_DATA_RD;
        else if (pick < 60) b.command = CMD_WRITE;
        else if (pick < 74) b.command = CMD_OPCODE;
        else if (pick < 88) b.command = CMD_OPERAND;
        else if (pick < 93) b.command = CMD_HOST_CMD;
        else if (pick < 98) b.command = CMD_HOST_FADE;
        else                b.command = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            b.address = hot_address($urandom_range(0, 20));
        end else if (pick < 45) begin
            // revisit a recent write target so stored bytes come back
            b.address = recent_wr[$urandom_range(0, 7)];
        end else if (pick < 65) begin
            case ($urandom_range(0, 2))
                0:       b.address = 16'hC000 | 16'($urandom_range(0, 16'h0FFF));
                1:       b.address = 16'hD000 | 16'($urandom_range(0, 16'h07FF));
                default: b.address = 16'hF000 | 16'($urandom_range(0, 16'h0FFF));
            endcase
        end else begin
            b.address = 16'($urandom_range(0, 16'hFFFF));
        end
        b.write_data = 8'($urandom_range(0, 255));
        if (b.command == CMD_WRITE) begin
            recent_wr[wr_ptr] = b.address;
            wr_ptr = (wr_ptr + 1) % 8;
        end
        return b;
    endfunction

    task automatic send_beat(input t_in beat);
        int gap;
        if (!bus_busy) begin
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        push <= 1'b1;
        i_item <= beat;
        bus_busy = 1;
        do @(posedge i_clk); while (full);
        decoded_q.push_back(decode_access(beat));
        burst_left--;
        if (burst_left == 0) begin
            push <= 1'b0;
            bus_busy = 0;
        end
    endtask

    // Drop push and hold until every pending result has been popped
    task automatic drain();
        if (bus_busy) begin
            push <= 1'b0;
            bus_busy = 0;
        end
        burst_left = 0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [21:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_BOARD_MODE) mode_q = val[1:0];
        else                       half_q = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_board(input logic [1:0] mode, input logic [21:0] half);
        drain();
        write_cfg(CFG_BOARD_MODE, {20'd0, mode});
        write_cfg(CFG_ROM_HALF, half);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_plain_board();
        set_board(MODE_PLAIN, '0);
        send_beat(access(CMD_WRITE, 16'hF004, 8'hFF));
        send_beat(access(CMD_DATA_RD, 16'hBFFF, 8'h00));
        send_beat(access(CMD_DATA_RD, 16'h0000, 8'h00));
        send_beat(access(CMD_WRITE, 16'hD7FF, 8'hA5));
        send_beat(access(CMD_DATA_RD, 16'hD7FF, 8'h00));
        send_beat(access(CMD_WRITE, 16'hF001, 8'h3C));
        send_beat(access(CMD_DATA_RD, 16'hF002, 8'h00));
        send_beat(access(CMD_HOST_CMD, 16'h0000, 8'hFF));
        send_beat(access(CMD_DATA_RD, 16'hF008, 8'h00));
        send_beat(access(CMD_HOST_FADE, 16'hFFFF, 8'h5A));
        send_beat(access(CMD_DATA_RD, 16'hF00A, 8'h00));
        send_beat(access(CMD_DATA_RD, 16'hFFFF, 8'h00));
        send_beat(access(CMD_UNUSED_LO, 16'hD000, 8'h12));
        send_beat(access(CMD_UNUSED_HI, 16'hFFFF, 8'hFF));
        drain();
    endtask

    task automatic test_audio_board();
        set_board(MODE_AUDIO, HALF_MAX);
        send_beat(access(CMD_WRITE, 16'hD000, 8'hFF));
        send_beat(access(CMD_WRITE, 16'hD001, 8'h01));
        send_beat(access(CMD_WRITE, 16'hD002, 8'h80));
        send_beat(access(CMD_WRITE, 16'hD003, 8'h57));
        send_beat(access(CMD_OPCODE, 16'h8000, 8'h00));
        send_beat(access(CMD_OPERAND, 16'hE000, 8'h00));
        send_beat(access(CMD_DATA_RD, 16'hD007, 8'h00));
        send_beat(access(CMD_DATA_RD, 16'hF00A, 8'h00));
        drain();
    endtask

    task automatic test_later_board();
        // unused mode decodes like the later board
        set_board(MODE_SPARE, '0);
        send_beat(access(CMD_OPCODE, 16'hD000, 8'h00));
        send_beat(access(CMD_DATA_RD, 16'hF008, 8'h00));
        drain();
    endtask

    task automatic test_random_mix(input logic [1:0] mode, input logic [21:0] half);
        set_board(mode, half);
        repeat (91) send_beat(random_access());
        drain();
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_result(input t_res want, input t_res got);
        if (got.route !== want.route) begin
            $error("route: expected %0d, got %0d", want.route, got.route);
            err_cnt++;
        end
        if (got.external_address !== want.external_address) begin
            $error("external_address: expected %h, got %h",
                   want.external_address, got.external_address);
            err_cnt++;
        end
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            err_cnt++;
        end
        if (got.external_data !== want.external_data) begin
            $error("external_data: expected %h, got %h",
                   want.external_data, got.external_data);
            err_cnt++;
        end
        if (got.audio_register !== want.audio_register) begin
            $error("audio_register: expected %h, got %h",
                   want.audio_register, got.audio_register);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_side
        t_res want;
        if (i_rst_n && !empty && pop) begin
            if (decoded_q.size() == 0) begin
                $error("result beat with no access pending");
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                check_result(want, o_result);
            end
        end
        // pick the pop stall pattern at random from four styles
        stall_tick++;
        if (stall_tick % 64 == 0) stall_style = $urandom_range(0, 3);
        case (stall_style)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 4) == 0);
            default: pop <= (stall_tick % 3 == 0);
        endcase
    end

    // ---------------------------------------------------------------- main

    initial begin
        int i;
        for (i = 0; i < SOUND_RAM_DEPTH; i++) snd_ram[i] = 8'h00;
        for (i = 0; i < 8; i++) recent_wr[i] = 16'hD000 + 16'(i);
        bank_q = '0;
        cmd_latch_q = '0;
        fade_latch_q = '0;
        acmd_hi_q = '0;
        acmd_lo_q = '0;
        mode_q = MODE_PLAIN;
        half_q = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the RAM clear pass is over
        do @(posedge i_clk); while (full);

        test_plain_board();
        test_audio_board();
        test_later_board();
        test_random_mix(MODE_PLAIN, '0);
        test_random_mix(MODE_AUDIO, HALF_MAX);
        test_random_mix(MODE_LATER, 22'($urandom_range(0, HALF_MAX)));
        test_random_mix(MODE_SPARE, 22'($urandom_range(0, HALF_MAX)));
        test_random_mix(MODE_AUDIO, 22'($urandom_range(0, HALF_MAX)));
        test_random_mix(MODE_AUDIO, '0);
        test_random_mix(MODE_PLAIN, 22'($urandom_range(0, HALF_MAX)));
        test_random_mix(MODE_LATER, HALF_MAX);

        drain();
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
